// ===== rtl/rbi_pkg.sv =====
// Shared types, constants and saturation helper for the rigid body integrator.
package rbi_pkg;

	localparam int FRACTION_BITS = 16;
	localparam int VALUE_WIDTH   = 32;
	localparam int IM_W          = VALUE_WIDTH - 1;
	localparam int DT_W          = FRACTION_BITS + 1;
	localparam int FM_W          = VALUE_WIDTH + IM_W + 1;
	localparam int DPROD_W       = VALUE_WIDTH + DT_W + 1;
	localparam int WIDE_W        = 2 * VALUE_WIDTH + 2;
	localparam int LANE_LAT      = 6;
	localparam int QDEPTH        = 16;
	localparam int PTR_W         = $clog2(QDEPTH);

	typedef logic signed [VALUE_WIDTH-1:0] val_t;
	typedef logic [IM_W-1:0]               im_t;
	typedef logic [DT_W-1:0]               dt_t;
	typedef logic signed [FM_W-1:0]        fm_t;
	typedef logic signed [DPROD_W-1:0]     dprod_t;
	typedef logic signed [WIDE_W-1:0]      wide_t;
	typedef logic [PTR_W:0]                cnt_t;

	localparam val_t VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam val_t VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam dt_t  DT_MAX  = dt_t'(1) << FRACTION_BITS;

	// register reset values: gravity Q16.16, time step unsigned Q1.16
	localparam dt_t  TIME_STEP_RESET = dt_t'(1092);
	localparam val_t GRAVITY_X_RESET = '0;
	localparam val_t GRAVITY_Y_RESET = val_t'(-642253);

	localparam logic [1:0] CFG_TIME_STEP = 2'd0;
	localparam logic [1:0] CFG_GRAVITY_X = 2'd1;
	localparam logic [1:0] CFG_GRAVITY_Y = 2'd2;

	typedef enum logic [1:0] {
		OP_EULER       = 2'd0,
		OP_VERLET_POS  = 2'd1,
		OP_VERLET_KICK = 2'd2,
		OP_RESERVED    = 2'd3
	} op_t;

	typedef struct packed {
		val_t v;
		logic s;
	} clamp_t;

	// one axis of one body entering a lane
	typedef struct packed {
		op_t  op;
		logic active;
		logic grav;
		val_t frc;
		im_t  im;
		val_t vel;
		val_t pos;
		dt_t  dt;
		val_t grav_acc;
	} lane_in_t;

	typedef struct packed {
		val_t vel;
		val_t pos;
		logic sat;
	} lane_out_t;

	typedef struct packed {
		logic valid;
		logic moved;
	} ctl_t;

	typedef struct packed {
		logic moved;
		val_t vel_x;
		val_t vel_y;
		val_t pos_x;
		val_t pos_y;
		logic saturated;
	} result_t;

	function automatic clamp_t sat_clamp(input wide_t x);
		clamp_t r;
		if (x > wide_t'(VAL_MAX)) begin
			r.v = VAL_MAX;
			r.s = 1'b1;
		end else if (x < wide_t'(VAL_MIN)) begin
			r.v = VAL_MIN;
			r.s = 1'b1;
		end else begin
			r.v = x[VALUE_WIDTH-1:0];
			r.s = 1'b0;
		end
		return r;
	endfunction

endpackage

// ===== rtl/rbi_lane.sv =====
// One axis of the integrator: six-stage pipeline from force to new velocity and position.
module rbi_lane (
	input  logic              clk,
	input  rbi_pkg::lane_in_t lane_in,
	output rbi_pkg::lane_out_t lane_out
);
	import rbi_pkg::*;

	// stage 1: force times inverse mass
	op_t  op_s1;
	logic act_s1, grav_s1;
	val_t g_s1, v_s1, p_s1;
	dt_t  dt_s1;
	fm_t  fm_s1;

	// stage 2: acceleration
	op_t  op_s2;
	logic act_s2, sat_s2;
	val_t a_s2, v_s2, p_s2;
	dt_t  dt_s2;

	// stage 3: a*dt and v*dt
	op_t    op_s3;
	logic   act_s3, sat_s3;
	val_t   v_s3, p_s3;
	dt_t    dt_s3;
	dprod_t ad_s3, vd_s3;

	// stage 4: new velocity, half kick, Verlet drift
	op_t  op_s4;
	logic act_s4, sat_s4;
	val_t vn_s4, h_s4, d1_s4, p_s4;
	dt_t  dt_s4;

	// stage 5: v_new*dt or h*dt
	op_t    op_s5;
	logic   act_s5, sat_s5;
	val_t   vn_s5, d1_s5, p_s5;
	dprod_t m_s5;

	// stage 6: output
	val_t vel_s6, pos_s6;
	logic sat_s6;

	clamp_t a0, ag, dv, hk, inc, vn, d1, q, pe, pv;
	logic   sat4, sat6;
	val_t   pn;

	always_ff @(posedge clk) begin
		op_s1   <= lane_in.op;
		act_s1  <= lane_in.active;
		grav_s1 <= lane_in.grav;
		g_s1    <= lane_in.grav_acc;
		v_s1    <= lane_in.vel;
		p_s1    <= lane_in.pos;
		dt_s1   <= lane_in.dt;
		fm_s1   <= lane_in.frc * $signed({1'b0, lane_in.im});
	end

	always_comb begin
		a0 = sat_clamp(wide_t'(fm_s1 >>> FRACTION_BITS));
		ag = sat_clamp(wide_t'(a0.v) + wide_t'(g_s1));
	end

	always_ff @(posedge clk) begin
		op_s2  <= op_s1;
		act_s2 <= act_s1;
		v_s2   <= v_s1;
		p_s2   <= p_s1;
		dt_s2  <= dt_s1;
		a_s2   <= grav_s1 ? ag.v : a0.v;
		sat_s2 <= a0.s | (grav_s1 & ag.s);
	end

	always_ff @(posedge clk) begin
		op_s3  <= op_s2;
		act_s3 <= act_s2;
		sat_s3 <= sat_s2;
		v_s3   <= v_s2;
		p_s3   <= p_s2;
		dt_s3  <= dt_s2;
		ad_s3  <= a_s2 * $signed({1'b0, dt_s2});
		vd_s3  <= v_s2 * $signed({1'b0, dt_s2});
	end

	always_comb begin
		dv   = sat_clamp(wide_t'(ad_s3 >>> FRACTION_BITS));
		hk   = sat_clamp(wide_t'(ad_s3 >>> (FRACTION_BITS + 1)));
		inc  = (op_s3 == OP_EULER) ? dv : hk;
		vn   = sat_clamp(wide_t'(v_s3) + wide_t'(inc.v));
		d1   = sat_clamp(wide_t'(vd_s3 >>> FRACTION_BITS));
		sat4 = sat_s3 | inc.s | vn.s | ((op_s3 == OP_VERLET_POS) & d1.s);
	end

	always_ff @(posedge clk) begin
		op_s4  <= op_s3;
		act_s4 <= act_s3;
		sat_s4 <= sat4;
		// hold the incoming velocity for a body that passes through
		vn_s4  <= act_s3 ? vn.v : v_s3;
		h_s4   <= hk.v;
		d1_s4  <= d1.v;
		p_s4   <= p_s3;
		dt_s4  <= dt_s3;
	end

	always_ff @(posedge clk) begin
		op_s5  <= op_s4;
		act_s5 <= act_s4;
		sat_s5 <= sat_s4;
		vn_s5  <= vn_s4;
		d1_s5  <= d1_s4;
		p_s5   <= p_s4;
		m_s5   <= ((op_s4 == OP_EULER) ? vn_s4 : h_s4) * $signed({1'b0, dt_s4});
	end

	always_comb begin
		q    = sat_clamp(wide_t'(m_s5 >>> FRACTION_BITS));
		pe   = sat_clamp(wide_t'(p_s5) + wide_t'(q.v));
		pv   = sat_clamp(wide_t'(p_s5) + wide_t'(d1_s5) + wide_t'(q.v));
		pn   = p_s5;
		sat6 = sat_s5;
		case (op_s5)
			OP_EULER: begin
				pn   = pe.v;
				sat6 = sat_s5 | q.s | pe.s;
			end
			OP_VERLET_POS: begin
				pn   = pv.v;
				sat6 = sat_s5 | q.s | pv.s;
			end
			default: begin
				pn   = p_s5;
				sat6 = sat_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		vel_s6 <= vn_s5;
		pos_s6 <= act_s5 ? pn : p_s5;
		sat_s6 <= act_s5 & sat6;
	end

	assign lane_out.vel = vel_s6;
	assign lane_out.pos = pos_s6;
	assign lane_out.sat = sat_s6;

endmodule

// ===== rtl/rbi_merge.sv =====
// Merging stage: joins the two axis lanes into one registered result.
module rbi_merge (
	input  logic               clk,
	input  logic               arst_n,
	input  rbi_pkg::ctl_t      ctl,
	input  rbi_pkg::lane_out_t lane_x,
	input  rbi_pkg::lane_out_t lane_y,
	output logic               push,
	output rbi_pkg::result_t   item
);
	import rbi_pkg::*;

	logic    valid_s7;
	result_t item_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		item_s7.moved     <= ctl.moved;
		item_s7.vel_x     <= lane_x.vel;
		item_s7.vel_y     <= lane_y.vel;
		item_s7.pos_x     <= lane_x.pos;
		item_s7.pos_y     <= lane_y.pos;
		item_s7.saturated <= lane_x.sat | lane_y.sat;
	end

	assign push = valid_s7;
	assign item = item_s7;

endmodule

// ===== rtl/rbi_outq.sv =====
// Output queue holding finished results until they are taken.
module rbi_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rbi_pkg::result_t push_item,
	input  logic             pop,
	output logic             not_empty,
	output rbi_pkg::result_t head
);
	import rbi_pkg::*;

	result_t mem_q [QDEPTH];
	cnt_t    wr_q, rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + cnt_t'(1);
			end
			if (pop) begin
				rd_q <= rd_q + cnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q[PTR_W-1:0]] <= push_item;
		end
	end

	assign not_empty = (wr_q != rd_q);
	assign head      = mem_q[rd_q[PTR_W-1:0]];

endmodule

// ===== rtl/rigid_body_integrator_step.sv =====
// Top level of the rigid body integrator: configuration, lanes, merge and output queue.
//
// One request is one 2D rigid body; each yields exactly one result, in order. A new body
// is taken every cycle while in_ready is high: the x and y axes run in two identical
// six-stage lanes (a multiply in stages one, three and five), a merge stage registers the
// joined result, and the output queue presents it, so a body passes through the lane
// stages, the merge register and the queue before it is offered. Up to sixteen bodies may
// be in flight; in_ready falls only once that many have been accepted and not yet taken,
// and the output queue can always hold them all, so a stalled consumer stops the input
// without loss. Opcode 0 is semi-implicit Euler, 1 the Verlet position pass with half
// kick, 2 the Verlet half kick alone; opcode 3 and bodies that are not dynamic pass
// through with moved and saturated low. Values are Q16.16 and saturate, raising
// saturated. time_step above 1.0 is used as 1.0. Write configuration only while idle.
module rigid_body_integrator_step (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	// request channel
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           opcode,
	input  logic                 is_dynamic,
	input  logic                 takes_gravity,
	input  rbi_pkg::val_t        force_x,
	input  rbi_pkg::val_t        force_y,
	input  rbi_pkg::im_t         inverse_mass,
	input  rbi_pkg::val_t        vel_in_x,
	input  rbi_pkg::val_t        vel_in_y,
	input  rbi_pkg::val_t        pos_in_x,
	input  rbi_pkg::val_t        pos_in_y,
	// result channel
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 moved,
	output rbi_pkg::val_t        vel_out_x,
	output rbi_pkg::val_t        vel_out_y,
	output rbi_pkg::val_t        pos_out_x,
	output rbi_pkg::val_t        pos_out_y,
	output logic                 saturated
);
	import rbi_pkg::*;

	dt_t       time_step_q;
	val_t      gravity_x_q, gravity_y_q;
	dt_t       dt_eff;
	op_t       op;
	logic      active;
	logic      in_acc, out_acc;
	cnt_t      cnt_q;
	ctl_t      ctl_q [LANE_LAT];
	lane_in_t  lin_x, lin_y;
	lane_out_t lout_x, lout_y;
	logic      push;
	result_t   push_item, head;

	// Configuration registers; an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RESET;
			gravity_x_q <= GRAVITY_X_RESET;
			gravity_y_q <= GRAVITY_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TIME_STEP: time_step_q <= cfg_data[DT_W-1:0];
				CFG_GRAVITY_X: gravity_x_q <= cfg_data[VALUE_WIDTH-1:0];
				CFG_GRAVITY_Y: gravity_y_q <= cfg_data[VALUE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Limit the step to 1.0.
	assign dt_eff = (time_step_q > DT_MAX) ? DT_MAX : time_step_q;

	assign op      = op_t'(opcode);
	// A body is integrated only when dynamic and the opcode means something.
	assign active  = is_dynamic & (op != OP_RESERVED);
	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_valid & out_ready;

	// Count bodies accepted but not yet delivered; the queue can always hold them all,
	// so the lanes never have to stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + cnt_t'(in_acc) - cnt_t'(out_acc);
		end
	end

	assign in_ready = (cnt_q < cnt_t'(QDEPTH));

	// Valid and moved flags travel beside the lanes, matched to their depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_LAT; i++) begin
				ctl_q[i] <= '0;
			end
		end else begin
			ctl_q[0].valid <= in_acc;
			ctl_q[0].moved <= active;
			for (int i = 1; i < LANE_LAT; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	// Split the body into its two axes.
	always_comb begin
		lin_x.op       = op;
		lin_x.active   = active;
		lin_x.grav     = takes_gravity;
		lin_x.frc      = force_x;
		lin_x.im       = inverse_mass;
		lin_x.vel      = vel_in_x;
		lin_x.pos      = pos_in_x;
		lin_x.dt       = dt_eff;
		lin_x.grav_acc = gravity_x_q;

		lin_y.op       = op;
		lin_y.active   = active;
		lin_y.grav     = takes_gravity;
		lin_y.frc      = force_y;
		lin_y.im       = inverse_mass;
		lin_y.vel      = vel_in_y;
		lin_y.pos      = pos_in_y;
		lin_y.dt       = dt_eff;
		lin_y.grav_acc = gravity_y_q;
	end

	rbi_lane u_lane_x (
		.clk      (clk),
		.lane_in  (lin_x),
		.lane_out (lout_x)
	);

	rbi_lane u_lane_y (
		.clk      (clk),
		.lane_in  (lin_y),
		.lane_out (lout_y)
	);

	rbi_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl_q[LANE_LAT-1]),
		.lane_x (lout_x),
		.lane_y (lout_y),
		.push   (push),
		.item   (push_item)
	);

	rbi_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (out_acc),
		.not_empty (out_valid),
		.head      (head)
	);

	assign moved     = head.moved;
	assign vel_out_x = head.vel_x;
	assign vel_out_y = head.vel_y;
	assign pos_out_x = head.pos_x;
	assign pos_out_y = head.pos_y;
	assign saturated = head.saturated;

endmodule

// ===== rtl/rbi_check.sv =====
// Port-level checker for the rigid body integrator, bound to the top level.
module rbi_check (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input logic          out_valid,
	input logic          out_ready,
	input logic          moved,
	input rbi_pkg::val_t vel_out_x,
	input rbi_pkg::val_t vel_out_y,
	input rbi_pkg::val_t pos_out_x,
	input rbi_pkg::val_t pos_out_y,
	input logic          saturated
);
	import rbi_pkg::*;

	logic [PTR_W+1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + (PTR_W+2)'(in_valid & in_ready)
				- (PTR_W+2)'(out_valid & out_ready);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({moved, vel_out_x, vel_out_y, pos_out_x, pos_out_y, saturated}))
		else $error("result changed or dropped while stalled");

	a_pass_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !moved |-> !saturated)
		else $error("pass-through result flagged as saturated");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != '0)
		else $error("result offered with no request outstanding");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pend_q != '0)
		else $error("input stalled while nothing is outstanding");

endmodule

bind rigid_body_integrator_step rbi_check u_rbi_check (.*);
